### sv/hci_h4_packet_deframer_macros.svh
// Assertion macros shared by the H4 deframer modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef HCI_H4_PACKET_DEFRAMER_MACROS_SVH
`define HCI_H4_PACKET_DEFRAMER_MACROS_SVH

// Condition that must hold in the same cycle as its trigger.
`define HHD_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define HHD_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### sv/hhd_pkg.sv
// Types and constants of the H4 packet deframer.
// No dependencies; imported by every module of the block.
package hhd_pkg;

	// Packet type bytes of the H4 stream.
	localparam logic [7:0] TYPE_COMMAND = 8'h01;
	localparam logic [7:0] TYPE_ACL     = 8'h02;

	// Reset value of the packet size limit.
	localparam logic [15:0] MAX_SIZE_RESET = 16'd512;

	// Byte count at which the header is complete (type byte plus header).
	localparam logic [15:0] HDR_END_CMD = 16'd4;
	localparam logic [15:0] HDR_END_ACL = 16'd5;

	// Width of the ACL connection handle and its mask.
	localparam int unsigned    HANDLE_W    = 12;
	localparam logic [15:0]    HANDLE_MASK = 16'h0fff;

	// Packet currently being parsed.
	typedef enum logic [1:0] {
		KIND_IDLE = 2'd0,
		KIND_CMD  = 2'd1,
		KIND_ACL  = 2'd2
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_TYPE = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// One result item.
	typedef struct packed {
		status_t              status;
		logic                 packet_kind;
		logic [15:0]          opcode;
		logic [HANDLE_W-1:0]  acl_handle;
		logic [3:0]           pb_bc_flags;
		logic [15:0]          payload_length;
		logic [7:0]           data_byte;
		logic                 last;
	} res_t;

	// Input byte held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_slot_t;

endpackage

### sv/hhd_in_stage.sv
// Input register of the H4 deframer with its stall logic.
// Depends on hhd_pkg.
module hhd_in_stage
	import hhd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_stall,
	input  logic       space,
	output logic       advance,
	output logic [7:0] byte_s1
);

	byte_slot_t slot_s1;

	// The held item moves on when the result register has room.
	assign advance  = slot_s1.valid && space;
	assign in_stall = slot_s1.valid && !space;
	assign byte_s1  = slot_s1.data;

	// Input register: loads on acceptance and empties when the held item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
		end else if (in_valid && !in_stall) begin
			slot_s1 <= '{valid: 1'b1, data: in_byte};
		end else if (advance) begin
			slot_s1.valid <= 1'b0;
		end
	end

endmodule

### sv/hhd_core.sv
// Parser state machine of the H4 deframer: header collection, length checks, results.
// Depends on hhd_pkg and the assertion macros header.
`include "hci_h4_packet_deframer_macros.svh"

module hhd_core
	import hhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [15:0] max_packet_bytes,
	input  logic        advance,
	input  logic [7:0]  byte_s1,
	output logic        res_valid,
	output res_t        res
);

	kind_t       kind_q, kind_n;
	logic [15:0] max_q;
	logic [15:0] count_q, count_n;
	logic [15:0] left_q, left_n;
	logic        too_long_q, too_long_n;
	logic [7:0]  hdr_q [4];
	logic        hdr_we;
	logic [1:0]  hdr_idx;
	logic [15:0] hdr_end;
	logic [15:0] len_new;
	logic [15:0] len_cur;
	logic [16:0] pkt_total;
	logic        go_idle;

	// Fill the header fields of a result from the first header word and length.
	function automatic res_t hdr_fields(input kind_t kind, input logic [15:0] word,
		input logic [15:0] len);
		res_t r;
		r = '0;
		if (kind == KIND_CMD) begin
			r.packet_kind = 1'b0;
			r.opcode      = word;
		end else begin
			r.packet_kind = 1'b1;
			r.acl_handle  = HANDLE_W'(word & HANDLE_MASK);
			r.pb_bc_flags = word[15:12];
		end
		r.payload_length = len;
		return r;
	endfunction

	// Header geometry and lengths.
	assign hdr_end  = (kind_q == KIND_CMD) ? HDR_END_CMD : HDR_END_ACL;
	assign hdr_idx  = count_q[1:0] - 2'd1;
	// Length once the final header byte arrives (it is the current byte).
	assign len_new  = (kind_q == KIND_CMD) ? {8'h00, byte_s1} : {byte_s1, hdr_q[2]};
	// Length of a packet whose header is complete.
	assign len_cur  = (kind_q == KIND_CMD) ? {8'h00, hdr_q[2]} : {hdr_q[3], hdr_q[2]};
	assign pkt_total = {1'b0, hdr_end} + {1'b0, len_new};

	// Next state and result for the byte that moves on this cycle.
	always_comb begin
		kind_n     = kind_q;
		count_n    = count_q;
		left_n     = left_q;
		too_long_n = too_long_q;
		hdr_we     = 1'b0;
		go_idle    = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		if (advance) begin
			if (count_q >= max_q) begin
				go_idle       = 1'b1;
				res_valid     = 1'b1;
				res.status    = ST_OVERFLOW;
				res.last      = 1'b1;
			end else begin
				case (kind_q)
					KIND_IDLE: begin
						if (byte_s1 == TYPE_COMMAND) begin
							kind_n  = KIND_CMD;
							count_n = 16'd1;
						end else if (byte_s1 == TYPE_ACL) begin
							kind_n  = KIND_ACL;
							count_n = 16'd1;
						end else begin
							go_idle    = 1'b1;
							res_valid  = 1'b1;
							res.status = ST_BAD_TYPE;
							res.last   = 1'b1;
						end
					end
					KIND_CMD, KIND_ACL: begin
						if (count_q < hdr_end) begin
							// Header byte.
							hdr_we  = 1'b1;
							count_n = count_q + 16'd1;
							if (count_n == hdr_end) begin
								left_n     = len_new;
								too_long_n = pkt_total > {1'b0, max_q};
								if (len_new == 16'd0) begin
									res        = hdr_fields(kind_q, {hdr_q[1], hdr_q[0]},
										len_new);
									res.status = ST_EMPTY;
									res.last   = 1'b1;
									res_valid  = 1'b1;
									go_idle    = 1'b1;
								end
							end
						end else begin
							// Payload byte; payload of an oversize packet is not forwarded.
							count_n = count_q + 16'd1;
							left_n  = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
							if (!too_long_q) begin
								res           = hdr_fields(kind_q, {hdr_q[1], hdr_q[0]},
									len_cur);
								res.status    = ST_PAYLOAD;
								res.data_byte = byte_s1;
								res.last      = (left_n == 16'd0);
								res_valid     = 1'b1;
								go_idle       = (left_n == 16'd0);
							end
						end
					end
					default: begin
						go_idle = 1'b1;
					end
				endcase
			end
		end
		if (go_idle) begin
			kind_n     = KIND_IDLE;
			count_n    = 16'd0;
			left_n     = 16'd0;
			too_long_n = 1'b0;
		end
	end

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_IDLE;
			count_q    <= 16'd0;
			left_q     <= 16'd0;
			too_long_q <= 1'b0;
		end else begin
			kind_q     <= kind_n;
			count_q    <= count_n;
			left_q     <= left_n;
			too_long_q <= too_long_n;
		end
	end

	// Packet size limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_SIZE_RESET;
		end else if (cfg_valid) begin
			max_q <= max_packet_bytes;
		end
	end

	// Header byte store; read only after the bytes of the current packet land.
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[hdr_idx] <= byte_s1;
		end
	end

	// An idle parser holds no count and no oversize mark.
	`HHD_ASSERT_SAME(a_idle_clear, kind_q == KIND_IDLE, count_q == 16'd0 && !too_long_q,
		"idle parser holds stale packet state")
	// An oversize packet never forwards payload.
	`HHD_ASSERT_SAME(a_no_fwd_too_long, res_valid && res.status == ST_PAYLOAD, !too_long_q,
		"payload forwarded from an oversize packet")
	// Any result marked last leaves the parser idle.
	`HHD_ASSERT_NEXT(a_last_idle, res_valid && res.last, kind_q == KIND_IDLE,
		"parser not idle after a final result")

endmodule

### sv/hhd_out_reg.sv
// Result register of the H4 deframer, decoupling the parser from the downstream stall.
// Depends on hhd_pkg.
module hhd_out_reg
	import hhd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic res_valid,
	input  res_t res,
	input  logic out_stall,
	output logic space,
	output logic out_valid,
	output res_t res_q
);

	logic out_valid_q;

	// Room for a new result when empty or when the held one leaves now.
	assign space     = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; loaded only with a new result.
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### sv/hci_h4_packet_deframer.sv
// H4 packet deframer: takes one stream byte per item, gives header-tagged payload bytes.
// A byte enters the input register, is parsed, and its result (if any) lands in the
// output register as the byte leaves the input register. One byte is taken every
// cycle as long as the output side is not stalled; the only loop is the parser state
// update, 16-bit compares, an increment and the length sum. Results: payload bytes
// with header fields, an empty packet marker, unknown-type and overflow errors, each
// error marked last. The size limit register is written through the cfg port and is
// meant to change only while no packet is in progress. Depends on hhd_pkg,
// hhd_in_stage, hhd_core, hhd_out_reg.
module hci_h4_packet_deframer
	import hhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_packet_bytes,
	// Byte input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        packet_kind,
	output logic [15:0] opcode,
	output logic [11:0] acl_handle,
	output logic [3:0]  pb_bc_flags,
	output logic [15:0] payload_length,
	output logic [7:0]  data_byte,
	output logic        last
);

	logic       space;
	logic       advance;
	logic [7:0] byte_s1;
	logic       res_valid;
	res_t       res;
	res_t       res_q;

	// The limit register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	// Input register.
	hhd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_stall (in_stall),
		.space    (space),
		.advance  (advance),
		.byte_s1  (byte_s1)
	);

	// Parser.
	hhd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid && cfg_ready),
		.max_packet_bytes (max_packet_bytes),
		.advance          (advance),
		.byte_s1          (byte_s1),
		.res_valid        (res_valid),
		.res              (res)
	);

	// Result register.
	hhd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.space     (space),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Result fields onto their ports.
	assign status         = res_q.status;
	assign packet_kind    = res_q.packet_kind;
	assign opcode         = res_q.opcode;
	assign acl_handle     = res_q.acl_handle;
	assign pb_bc_flags    = res_q.pb_bc_flags;
	assign payload_length = res_q.payload_length;
	assign data_byte      = res_q.data_byte;
	assign last           = res_q.last;

endmodule
